// ===== rtl/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, constants and helper functions of the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int MAX_WORDS = 64;
    localparam int WORD_W    = 64;
    localparam int ADDR_W    = 6;
    localparam int BIT_W     = 6;
    localparam int IDX_W     = 12;
    localparam int CNT_W     = 7;

    localparam logic [CNT_W-1:0] POOL_WORDS_RST = 7'd64;
    localparam logic             REG_POOL_WORDS = 1'b0;

    typedef enum logic {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        ST_ALLOC     = 2'd0,
        ST_FREED     = 2'd1,
        ST_EXHAUSTED = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_SCAN,
        S_FREE,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        t_status          status;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    // Position of the lowest clear bit; zero when the word is all ones.
    function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!w[i]) begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

// ===== rtl/bpa_ram.sv =====
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpa_ctrl
// Request sequencer: wraps the hint into the pool, scans bitmap words through
// the memory with one read per cycle, and performs the read-modify-write of
// the chosen word. Per-word valid bits make never-written words read as zero.
// ----------------------------------------------------------------------------
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CNT_W-1:0]  i_pool_words,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  t_mode             i_mode,
    input  logic [IDX_W-1:0]  i_page_index,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output t_result           o_res,
    output t_ram_req          o_ram,
    input  logic [WORD_W-1:0] i_ram_rdata
);

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_hint, n_hint;
    logic [CNT_W-1:0]    r_start, n_start;
    logic [ADDR_W-1:0]   r_raddr, n_raddr;
    logic [CNT_W-1:0]    r_issue_cnt, n_issue_cnt;
    logic [CNT_W-1:0]    r_chk_cnt, n_chk_cnt;
    logic                r_rd_pend;
    logic [ADDR_W-1:0]   r_rd_addr;
    logic [MAX_WORDS-1:0] r_valid, n_valid;
    logic [BIT_W-1:0]    r_page_bit, n_page_bit;
    t_result             r_res, n_res;

    logic [CNT_W-1:0]    words;
    logic [WORD_W-1:0]   cur_word;
    logic [BIT_W-1:0]    zero_pos;
    logic [CNT_W-1:0]    raddr_inc;
    logic                issue;
    logic                found;

    assign words     = (i_pool_words > CNT_W'(MAX_WORDS)) ? CNT_W'(MAX_WORDS) : i_pool_words;
    assign cur_word  = r_valid[r_rd_addr] ? i_ram_rdata : '0;
    assign zero_pos  = lowest_zero(cur_word);
    assign raddr_inc = {1'b0, r_raddr} + 1'b1;
    assign found     = r_rd_pend && (cur_word != '1);

    always_comb begin
        n_state     = r_state;
        n_hint      = r_hint;
        n_start     = r_start;
        n_raddr     = r_raddr;
        n_issue_cnt = r_issue_cnt;
        n_chk_cnt   = r_chk_cnt;
        n_valid     = r_valid;
        n_page_bit  = r_page_bit;
        n_res       = r_res;
        o_ram       = '0;
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        issue       = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_res.index = '0;
                    if (i_mode == MODE_ALLOC) begin
                        if (words == '0) begin
                            n_res.status = ST_EXHAUSTED;
                            n_state      = S_RESP;
                        end else begin
                            n_start = {1'b0, r_hint};
                            n_state = S_MOD;
                        end
                    end else begin
                        if (CNT_W'(i_page_index[IDX_W-1:BIT_W]) < words) begin
                            o_ram.re   = 1'b1;
                            o_ram.raddr = i_page_index[IDX_W-1:BIT_W];
                            n_page_bit = i_page_index[BIT_W-1:0];
                            n_state    = S_FREE;
                        end else begin
                            n_res.status = ST_RANGE;
                            n_state      = S_RESP;
                        end
                    end
                end
            end
            S_MOD: begin
                if (r_start >= words) begin
                    n_start = r_start - words;
                end else begin
                    n_raddr     = r_start[ADDR_W-1:0];
                    n_issue_cnt = '0;
                    n_chk_cnt   = '0;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                issue = (r_issue_cnt < words) && !found;
                if (issue) begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = r_raddr;
                    n_raddr     = (raddr_inc == words) ? '0 : raddr_inc[ADDR_W-1:0];
                    n_issue_cnt = r_issue_cnt + 1'b1;
                end
                if (r_rd_pend) begin
                    n_chk_cnt = r_chk_cnt + 1'b1;
                end
                if (found) begin
                    o_ram.we           = 1'b1;
                    o_ram.waddr        = r_rd_addr;
                    o_ram.wdata        = cur_word | (WORD_W'(1) << zero_pos);
                    n_valid[r_rd_addr] = 1'b1;
                    n_hint             = r_rd_addr;
                    n_res.index        = {r_rd_addr, zero_pos};
                    n_res.status       = ST_ALLOC;
                    n_state            = S_RESP;
                end else if (r_rd_pend && (r_chk_cnt + 1'b1 == words)) begin
                    n_res.status = ST_EXHAUSTED;
                    n_state      = S_RESP;
                end
            end
            S_FREE: begin
                o_ram.we           = 1'b1;
                o_ram.waddr        = r_rd_addr;
                o_ram.wdata        = cur_word & ~(WORD_W'(1) << r_page_bit);
                n_valid[r_rd_addr] = 1'b1;
                n_res.status       = ST_FREED;
                n_state            = S_RESP;
            end
            S_RESP: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hint      <= '0;
            r_start     <= '0;
            r_raddr     <= '0;
            r_issue_cnt <= '0;
            r_chk_cnt   <= '0;
            r_rd_pend   <= 1'b0;
            r_rd_addr   <= '0;
            r_valid     <= '0;
        end else begin
            r_state     <= n_state;
            r_hint      <= n_hint;
            r_start     <= n_start;
            r_raddr     <= n_raddr;
            r_issue_cnt <= n_issue_cnt;
            r_chk_cnt   <= n_chk_cnt;
            r_rd_pend   <= o_ram.re;
            if (o_ram.re) begin
                r_rd_addr <= o_ram.raddr;
            end
            r_valid     <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page_bit <= n_page_bit;
        r_res      <= n_res;
    end

    assign o_res = r_res;

endmodule

// ===== rtl/bitmap_page_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// Next-fit page allocator over a 64 x 64-bit usage bitmap held in RAM.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Contents
// s_axis    in         s_axis_tvalid/tready      tdata page_index, tuser mode
// m_axis    out        m_axis_tvalid/tready      tdata allocated_index, tuser status
// apb       in         psel/penable/pready       pool_words at byte address 0
//
// A free reads its word on acceptance, writes it in S_FREE and answers from S_RESP; a
// free out of range or an allocate with no words goes to S_RESP at once. An allocate
// wraps a stale hint in S_MOD by subtracting the word count, then reads one bitmap
// word per cycle in S_SCAN. Requests are taken only in idle, after S_RESP. Reset is
// synchronous and clears control state, not results. A waiting response lets one more
// request finish; the request after it stalls until the output register empties.
// ----------------------------------------------------------------------------
module bitmap_page_allocator
    import bpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] page_index, [15:12] zero
    input  logic        s_axis_tuser,   // [0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [11:0] allocated_index, [15:12] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [CNT_W-1:0]  r_pool_words;
    logic              r_out_vld;
    t_result           r_out;
    logic              res_valid;
    logic              res_ready;
    t_result           res;
    t_ram_req          ram;
    logic [WORD_W-1:0] ram_rdata;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_POOL_WORDS);
    assign prdata = (paddr[2] == REG_POOL_WORDS) ? {25'd0, r_pool_words} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_words <= POOL_WORDS_RST;
        end else if (cfg_wr) begin
            r_pool_words <= pwdata[CNT_W-1:0];
        end
    end

    bpa_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pool_words (r_pool_words),
        .i_req_valid  (s_axis_tvalid),
        .o_req_ready  (s_axis_tready),
        .i_mode       (t_mode'(s_axis_tuser)),
        .i_page_index (s_axis_tdata[IDX_W-1:0]),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res),
        .o_ram        (ram),
        .i_ram_rdata  (ram_rdata)
    );

    bpa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram.we),
        .i_waddr (ram.waddr),
        .i_wdata (ram.wdata),
        .i_re    (ram.re),
        .i_raddr (ram.raddr),
        .o_rdata (ram_rdata)
    );

    assign res_ready = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_ready) begin
            r_out_vld <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {4'd0, r_out.index};
    assign m_axis_tuser  = r_out.status;

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while a previous one is in progress");

    a_no_ram_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram.we && ram.re && (ram.waddr == ram.raddr)))
        else $error("bitmap word read and written in the same cycle");

    a_response_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res_ready) |=> m_axis_tvalid)
        else $error("response lost on its way to the output register");

    a_fail_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_ALLOC)) |-> (m_axis_tdata == '0))
        else $error("nonzero index on a response without allocation");

endmodule
